[design/rfa_pkg.sv]
// shared constants, types and helpers for the register file alu
`default_nettype none

package rfa_pkg;

   localparam int DATA_W   = 32;
   localparam int IDX_W    = 4;
   localparam int MODE_W   = 3;
   localparam int NUM_REGS = 16;
   localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CNT_W    = $clog2(DATA_W + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_MOVE_REG = 3'd0,
      MODE_MOVE_IMM = 3'd1,
      MODE_ADD      = 3'd2,
      MODE_SUB      = 3'd3,
      MODE_MUL      = 3'd4,
      MODE_DIV      = 3'd5,
      MODE_MOD      = 3'd6
   } mode_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [REG_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
      return REG_AW'(idx);
   endfunction

   function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
      return 32'(idx) < NUM_REGS;
   endfunction

endpackage

`default_nettype wire

[design/register_file_alu_top.sv]
// register file alu: ram-held register file, alu, iterative divider and response register
// move, add, sub and mul pass through the execute and writeback states; writeback waits while the response is stalled
// div and mod run the divider in between: 32 quotient steps plus read, sign fix and writeback
// a zero divisor is caught in the execute state, before the divider
// one request at a time: a new one is accepted only once the previous response has been loaded
// reset is synchronous: it clears the valid bits so every register reads as zero
`default_nettype none

module register_file_alu_top import rfa_pkg::*; (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire [MODE_W-1:0]        req_mode,
   input  wire [IDX_W-1:0]         req_dest_index,
   input  wire [IDX_W-1:0]         req_src_index,
   input  wire [IDX_W-1:0]         req_second_index,
   input  wire signed [DATA_W-1:0] req_immediate,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_written_value,
   output logic                    rsp_divide_error
);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV_WAIT, ST_DONE} state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [IDX_W-1:0]  dest_ff, dest_in;
   logic [DATA_W-1:0] imm_ff, imm_in;
   logic              a_ok_ff, a_ok_in;
   logic              b_ok_ff, b_ok_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              err_ff, err_in;
   logic              wr_ff, wr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_err_ff, rsp_err_in;
   logic [NUM_REGS-1:0] reg_valid_ff, reg_valid_in;

   logic              req_accept;
   logic              rsp_load;
   logic              ram_wr_en;
   logic [DATA_W-1:0] ram_a_q, ram_b_q;
   logic [DATA_W-1:0] op_a, op_b;
   logic [DATA_W-1:0] product;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);

   // entries never written since reset read as zero through the valid bits
   assign op_a    = a_ok_ff ? ram_a_q : '0;
   assign op_b    = b_ok_ff ? ram_b_q : '0;
   assign product = op_a * op_b;

   // two copies of the register file, one per source operand
   rfa_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (to_addr(dest_ff)),
      .wr_data (res_ff),
      .rd_en   (req_accept),
      .rd_addr (to_addr(req_src_index)),
      .rd_data (ram_a_q)
   );

   rfa_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (to_addr(dest_ff)),
      .wr_data (res_ff),
      .rd_en   (req_accept),
      .rd_addr (to_addr(req_second_index)),
      .rd_data (ram_b_q)
   );

   rfa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      dest_in      = dest_ff;
      imm_in       = imm_ff;
      a_ok_in      = a_ok_ff;
      b_ok_in      = b_ok_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      wr_in        = wr_ff;
      reg_valid_in = reg_valid_ff;
      rsp_load     = 1'b0;
      ram_wr_en    = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = op_a;
      div_req.divisor  = op_b;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in  = mode_type'(req_mode);
               dest_in  = req_dest_index;
               imm_in   = req_immediate;
               a_ok_in  = idx_in_range(req_src_index) &&
                          reg_valid_ff[to_addr(req_src_index)];
               b_ok_in  = idx_in_range(req_second_index) &&
                          reg_valid_ff[to_addr(req_second_index)];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            err_in   = 1'b0;
            wr_in    = 1'b1;
            state_in = ST_DONE;
            case (mode_ff)
               MODE_MOVE_REG: res_in = op_a;
               MODE_MOVE_IMM: res_in = imm_ff;
               MODE_ADD:      res_in = op_a + op_b;
               MODE_SUB:      res_in = op_a - op_b;
               MODE_MUL:      res_in = product;
               MODE_DIV, MODE_MOD: begin
                  if (op_b == '0) begin
                     err_in = 1'b1;
                     wr_in  = 1'b0;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV_WAIT;
                  end
               end
               default: begin
                  wr_in = 1'b0;
               end
            endcase
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               res_in   = (mode_ff == MODE_DIV) ? div_rsp.quotient : div_rsp.remainder;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load  = 1'b1;
               ram_wr_en = wr_ff && idx_in_range(dest_ff);
               if (ram_wr_en) begin
                  reg_valid_in[to_addr(dest_ff)] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_ff;
         rsp_err_in   = err_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         reg_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_valid_ff <= reg_valid_in;
      end
      mode_ff      <= mode_in;
      dest_ff      <= dest_in;
      imm_ff       <= imm_in;
      a_ok_ff      <= a_ok_in;
      b_ok_ff      <= b_ok_in;
      res_ff       <= res_in;
      err_ff       <= err_in;
      wr_ff        <= wr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_written_value = rsp_value_ff;
   assign rsp_divide_error  = rsp_err_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_EXEC)
      else $error("accepted request did not move to execute");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside the wait state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside writeback");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> rsp_value_ff == '0)
      else $error("divide error response carries a non-zero value");

endmodule

`default_nettype wire

[design/rfa_ram.sv]
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module rfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                 clock,
   input  wire                 wr_en,
   input  wire [AW-1:0]        wr_addr,
   input  wire [WIDTH-1:0]     wr_data,
   input  wire                 rd_en,
   input  wire [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/rfa_divider.sv]
// radix-2 restoring signed divider, one quotient bit per cycle
`default_nettype none

module rfa_divider import rfa_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire div_req_type  div_req,
   output div_rsp_type       div_rsp
);

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIX} state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;
   logic              done_ff, done_in;
   logic [DATA_W-1:0] q_out_ff, q_out_in;
   logic [DATA_W-1:0] r_out_ff, r_out_in;

   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      done_in  = 1'b0;
      q_out_in = q_out_ff;
      r_out_in = r_out_ff;
      case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               // magnitudes; the most negative value maps onto 2^31 unsigned
               rem_in   = '0;
               quo_in   = div_req.dividend[DATA_W-1] ? (~div_req.dividend + 1'b1)
                                                     : div_req.dividend;
               dvs_in   = div_req.divisor[DATA_W-1] ? (~div_req.divisor + 1'b1)
                                                    : div_req.divisor;
               neg_q_in = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
               neg_r_in = div_req.dividend[DATA_W-1];
               count_in = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            if (!diff[DATA_W]) begin
               rem_in = diff[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(DATA_W - 1)) begin
               state_in = DV_FIX;
            end
         end
         DV_FIX: begin
            q_out_in = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
            r_out_in = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      q_out_ff <= q_out_in;
      r_out_ff <= r_out_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = q_out_ff;
   assign div_rsp.remainder = r_out_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> state_ff == DV_IDLE)
      else $error("divider started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

   a_done_after_fix: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(state_ff) == DV_FIX)
      else $error("divider done without fix-up step");

endmodule

`default_nettype wire
